// ===== rtl/vector_window_write_watchpoint_defines.svh =====
// Assertion macros used by the watchpoint RTL.
`ifndef VECTOR_WINDOW_WRITE_WATCHPOINT_DEFINES_SVH
`define VECTOR_WINDOW_WRITE_WATCHPOINT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VWWP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define VWWP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vwwp_pkg.sv =====
package vwwp_pkg;

   // Default window and trap placement.
   localparam int unsigned WIN_BASE_DEF         = 65504;
   localparam int unsigned WIN_BYTES_DEF        = 32;
   localparam int unsigned TRAP_VECTOR_ADDR_DEF = 65532;
   localparam int unsigned TRAP_CODE_ADDR_DEF   = 65504;
   localparam int unsigned TRAP_CODE_LEN_DEF    = 16;

   // Beat layouts.
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;

   // Action codes carried in the request tuser.
   typedef enum logic [2:0] {
      ACT_CONTROL = 3'd0,
      ACT_READ    = 3'd1,
      ACT_WRITE   = 3'd2,
      ACT_LOAD    = 3'd3,
      ACT_RESET   = 3'd4
   } action_type;

   // Trap snippet overlaid on arming.
   localparam int SNIP_LEN = 16;
   localparam logic [7:0] TRAP_SNIP [SNIP_LEN] = '{
      8'h30, 8'hE4, 8'hCE, 8'hFF, 8'hD0, 8'h86, 8'h0C, 8'hE6,
      8'h80, 8'hE7, 8'hC0, 8'h4A, 8'h26, 8'hF9, 8'h20, 8'hFE
   };

   // Snippet byte at a position; positions past the table read as 0xFF.
   function automatic logic [7:0] trap_snip_byte(input int idx);
      logic [7:0] b;
      if (idx >= 0 && idx < SNIP_LEN) begin
         b = TRAP_SNIP[idx[3:0]];
      end else begin
         b = 8'hFF;
      end
      return b;
   endfunction

endpackage

// ===== rtl/vector_window_write_watchpoint.sv =====
// An accepted request beat passes through the input register and then the response register.
// Throughput: one request beat per cycle while the response side keeps up; when a
// response stalls, the input register holds one more beat and then req_tready drops.
// The register-based window store takes the whole arm overlay in a single state update.
// Reset (synchronous, active high) empties both stages, clears the window
// bytes, the saved vector, the armed flag and the NMI request.
`include "vector_window_write_watchpoint_defines.svh"

module vector_window_write_watchpoint
   import vwwp_pkg::*;
#(
   parameter int unsigned WIN_BASE         = WIN_BASE_DEF,
   parameter int unsigned WIN_BYTES        = WIN_BYTES_DEF,
   parameter int unsigned TRAP_VECTOR_ADDR = TRAP_VECTOR_ADDR_DEF,
   parameter int unsigned TRAP_CODE_ADDR   = TRAP_CODE_ADDR_DEF,
   parameter int unsigned TRAP_CODE_LEN    = TRAP_CODE_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // address [15:0], data [23:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action [2:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_data [7:0], write_blocked [8], nmi_out [9], is_armed [10], zero [15:11]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = (WIN_BYTES > 1) ? $clog2(WIN_BYTES) : 1;

   // Window offsets of the vector and the snippet, modulo 2^16.
   localparam int VEC_OFF  = (int'(TRAP_VECTOR_ADDR) - int'(WIN_BASE)) & 32'hFFFF;
   localparam int VEC1_OFF = (VEC_OFF + 1) & 32'hFFFF;
   localparam int CODE_OFF = (int'(TRAP_CODE_ADDR) - int'(WIN_BASE)) & 32'hFFFF;
   localparam bit VEC_IN   = VEC_OFF < int'(WIN_BYTES);
   localparam bit VEC1_IN  = VEC1_OFF < int'(WIN_BYTES);
   localparam logic [IDX_W-1:0] VEC_IDX  = VEC_OFF[IDX_W-1:0];
   localparam logic [IDX_W-1:0] VEC1_IDX = VEC1_OFF[IDX_W-1:0];
   localparam logic [7:0] CODE_HI = 8'(TRAP_CODE_ADDR >> 8);
   localparam logic [7:0] CODE_LO = 8'(TRAP_CODE_ADDR);
   localparam logic [16:0] LOAD_LO = 17'(WIN_BASE);
   localparam logic [16:0] LOAD_HI = 17'(WIN_BASE + WIN_BYTES);

   // Input register.
   logic        in_valid_ff;
   action_type  in_action_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_data_ff;

   // Response register.
   logic        out_valid_ff;
   logic [7:0]  out_rd_ff;
   logic        out_blk_ff;

   // Block state.
   logic [7:0] shadow_ff [WIN_BYTES];
   logic [7:0] shadow_in [WIN_BYTES];
   logic       armed_ff, armed_in;
   logic       nmi_ff, nmi_in;
   logic [7:0] sv_hi_ff, sv_hi_in;
   logic [7:0] sv_lo_ff, sv_lo_in;
   logic [7:0] rd_in;
   logic       blk_in;

   logic        advance;
   logic        in_win;
   logic        load_hit;
   logic [16:0] load_off;

   // Handshake: the input stage moves on when the response register is free.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, armed_ff, nmi_ff, out_blk_ff, out_rd_ff};

   // Address decode for window accesses and absolute loads.
   assign in_win   = in_addr_ff < 16'(WIN_BYTES);
   assign load_off = {1'b0, in_addr_ff} - LOAD_LO;
   assign load_hit = ({1'b0, in_addr_ff} >= LOAD_LO) && ({1'b0, in_addr_ff} < LOAD_HI);

   // Next state and response for the beat in the input register.
   always_comb begin
      int rel;
      rel       = 0;
      shadow_in = shadow_ff;
      armed_in  = armed_ff;
      nmi_in    = nmi_ff;
      sv_hi_in  = sv_hi_ff;
      sv_lo_in  = sv_lo_ff;
      rd_in     = 8'h00;
      blk_in    = 1'b0;
      unique case (in_action_ff)
         ACT_CONTROL: begin
            if (in_data_ff != 8'h00) begin
               if (!armed_ff) begin
                  // Save the vector, overlay the snippet, repoint the vector.
                  sv_hi_in = VEC_IN ? shadow_ff[VEC_IDX] : 8'hFF;
                  sv_lo_in = VEC1_IN ? shadow_ff[VEC1_IDX] : 8'hFF;
                  for (int j = 0; j < int'(WIN_BYTES); j++) begin
                     rel = (j - CODE_OFF) & 32'hFFFF;
                     if (rel < int'(TRAP_CODE_LEN)) begin
                        shadow_in[j] = trap_snip_byte(rel);
                     end
                  end
                  if (VEC_IN) begin
                     shadow_in[VEC_IDX] = CODE_HI;
                  end
                  if (VEC1_IN) begin
                     shadow_in[VEC1_IDX] = CODE_LO;
                  end
                  armed_in = 1'b1;
               end
            end else if (armed_ff) begin
               if (VEC_IN) begin
                  shadow_in[VEC_IDX] = sv_hi_ff;
               end
               if (VEC1_IN) begin
                  shadow_in[VEC1_IDX] = sv_lo_ff;
               end
               armed_in = 1'b0;
               nmi_in   = 1'b0;
            end
         end
         ACT_READ: begin
            rd_in = in_win ? shadow_ff[in_addr_ff[IDX_W-1:0]] : 8'hFF;
         end
         ACT_WRITE: begin
            if (in_win) begin
               if (armed_ff) begin
                  nmi_in = 1'b1;
                  blk_in = 1'b1;
               end else begin
                  shadow_in[in_addr_ff[IDX_W-1:0]] = in_data_ff;
               end
            end
         end
         ACT_LOAD: begin
            if (load_hit) begin
               shadow_in[load_off[IDX_W-1:0]] = in_data_ff;
            end
         end
         ACT_RESET: begin
            if (armed_ff) begin
               if (VEC_IN) begin
                  shadow_in[VEC_IDX] = sv_hi_ff;
               end
               if (VEC1_IN) begin
                  shadow_in[VEC1_IDX] = sv_lo_ff;
               end
            end
            armed_in = 1'b0;
            nmi_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Input register: takes a request beat whenever it is empty or moving on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tuser);
         in_addr_ff   <= req_tdata[15:0];
         in_data_ff   <= req_tdata[23:16];
      end
   end

   // Response register: holds a beat until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_rd_ff  <= rd_in;
         out_blk_ff <= blk_in;
      end
   end

   // Block state is updated once for each beat leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < int'(WIN_BYTES); j++) begin
            shadow_ff[j] <= 8'h00;
         end
         armed_ff <= 1'b0;
         nmi_ff   <= 1'b0;
         sv_hi_ff <= 8'h00;
         sv_lo_ff <= 8'h00;
      end else if (advance) begin
         shadow_ff <= shadow_in;
         armed_ff  <= armed_in;
         nmi_ff    <= nmi_in;
         sv_hi_ff  <= sv_hi_in;
         sv_lo_ff  <= sv_lo_in;
      end
   end

   // The NMI request is only ever raised while armed and drops on disarm.
   `VWWP_ASSERT_NOW(a_nmi_needs_armed, clock, reset, nmi_ff, armed_ff, "NMI request while disarmed")
   // A blocked write shows up with both the NMI request and the armed level.
   `VWWP_ASSERT_NOW(a_blocked_flags, clock, reset, out_valid_ff && out_blk_ff, nmi_ff && armed_ff, "blocked write without NMI")
   // An arm request taken while disarmed leaves the block armed.
   `VWWP_ASSERT_NEXT(a_arm_takes, clock, reset, advance && in_action_ff == ACT_CONTROL && in_data_ff != 8'h00, armed_ff, "arm did not take")
   // A beat held in the input register is not dropped while the output stalls.
   `VWWP_ASSERT_NEXT(a_input_holds, clock, reset, in_valid_ff && !advance, in_valid_ff && out_valid_ff, "input beat lost")

endmodule
